// ===== rtl/ccfr_pkg.sv =====
// ----------------------------------------------------------------------------
// CRC-8 checked frame receiver package
// Shared types, constants and the byte-wide CRC-8 update used by the
// frame receiver.
// ----------------------------------------------------------------------------
package ccfr_pkg;

    // CRC-8, polynomial 0x31, initial value 0xFF, MSB first, no final xor.
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_TOP  = 8'h80;

    // The byte counter stops at its largest value.
    localparam logic [3:0] COUNT_MAX = 4'd15;

    // Width of the relay state field.
    localparam int RELAY_BITS = 6;

    // Status reported on the last byte of a transfer.
    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_LENGTH = 2'd1,
        STATUS_BAD_CRC    = 2'd2
    } frame_status_t;

    // One result item.
    typedef struct packed {
        frame_status_t         status;
        logic [7:0]            unit_id;
        logic [RELAY_BITS-1:0] relays;
        logic [15:0]           volume;
        logic                  mute;
    } result_t;

    // Feed one byte into the CRC, bit by bit, MSB first.
    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 8'h00) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/crc8_checked_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// CRC-8 checked frame receiver: one byte per handshake, a result on the last byte of a transfer.
// The result of a final byte is registered in the output register, or in the skid entry while the output is held.
// Throughput: one byte per cycle while the skid entry is free; a two-entry result stage absorbs stalls.
// Reset clears the counter, the CRC to 0xFF and all staged and held values.
// ----------------------------------------------------------------------------
module crc8_checked_frame_receiver #(
    parameter int RELAY_COUNT = 6
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_end_of_transfer,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_frame_status,
    output logic [7:0]  m_unit_id,
    output logic [ccfr_pkg::RELAY_BITS-1:0] m_relay_bits,
    output logic [15:0] m_volume_level,
    output logic        m_mute_flag
);

    // Frame layout positions derived from the relay count.
    localparam logic [3:0] POS_VOL_LO  = 4'(RELAY_COUNT + 1);
    localparam logic [3:0] POS_VOL_HI  = 4'(RELAY_COUNT + 2);
    localparam logic [3:0] POS_MUTE    = 4'(RELAY_COUNT + 3);
    localparam logic [3:0] PAYLOAD_LEN = 4'(RELAY_COUNT + 4);

    // Frame accumulation state.
    logic [3:0]  count_reg, count_next;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  staged_id_reg, staged_id_next;
    logic [ccfr_pkg::RELAY_BITS-1:0] staged_relays_reg, staged_relays_next;
    logic [15:0] staged_volume_reg, staged_volume_next;
    logic        staged_mute_reg, staged_mute_next;

    // Values of the last valid frame.
    logic [7:0]  held_id_reg, held_id_next;
    logic [ccfr_pkg::RELAY_BITS-1:0] held_relays_reg, held_relays_next;
    logic [15:0] held_volume_reg, held_volume_next;
    logic        held_mute_reg, held_mute_next;

    // Output register and skid entry.
    ccfr_pkg::result_t out_reg, out_next;
    ccfr_pkg::result_t skid_reg, skid_next;
    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;

    logic              accept;
    logic              accept_last;
    logic              take;
    ccfr_pkg::frame_status_t status;
    ccfr_pkg::result_t result;

    // Input is taken whenever the skid entry is free.
    assign s_ready     = !skid_valid_reg;
    assign accept      = s_valid && s_ready;
    assign accept_last = accept && s_end_of_transfer;
    assign take        = out_valid_reg && m_ready;

    // Frame status: length is checked before the CRC.
    always_comb begin
        if (count_reg != PAYLOAD_LEN) begin
            status = ccfr_pkg::STATUS_BAD_LENGTH;
        end else if (s_rx_byte != crc_reg) begin
            status = ccfr_pkg::STATUS_BAD_CRC;
        end else begin
            status = ccfr_pkg::STATUS_OK;
        end
    end

    // Staging, CRC and count for non-final bytes; a final byte holds an OK frame and resets count and CRC.
    always_comb begin
        count_next         = count_reg;
        crc_next           = crc_reg;
        staged_id_next     = staged_id_reg;
        staged_relays_next = staged_relays_reg;
        staged_volume_next = staged_volume_reg;
        staged_mute_next   = staged_mute_reg;
        held_id_next       = held_id_reg;
        held_relays_next   = held_relays_reg;
        held_volume_next   = held_volume_reg;
        held_mute_next     = held_mute_reg;

        if (accept && !s_end_of_transfer) begin
            if (count_reg == 4'd0) begin
                staged_id_next = s_rx_byte;
            end
            for (int i = 0; i < ccfr_pkg::RELAY_BITS; i++) begin
                if (i < RELAY_COUNT && count_reg == 4'(i + 1)) begin
                    staged_relays_next[i] = (s_rx_byte != 8'h00);
                end
            end
            if (count_reg == POS_VOL_LO) begin
                staged_volume_next[7:0] = s_rx_byte;
            end
            if (count_reg == POS_VOL_HI) begin
                staged_volume_next[15:8] = s_rx_byte;
            end
            if (count_reg == POS_MUTE) begin
                staged_mute_next = (s_rx_byte != 8'h00);
            end
            crc_next = ccfr_pkg::crc_feed(crc_reg, s_rx_byte);
            if (count_reg != ccfr_pkg::COUNT_MAX) begin
                count_next = count_reg + 4'd1;
            end
        end else if (accept_last) begin
            if (status == ccfr_pkg::STATUS_OK) begin
                held_id_next     = staged_id_reg;
                held_relays_next = staged_relays_reg;
                held_volume_next = staged_volume_reg;
                held_mute_next   = staged_mute_reg;
            end
            count_next = 4'd0;
            crc_next   = ccfr_pkg::CRC_INIT;
        end
    end

    // Result item of a final byte carries the updated held values.
    always_comb begin
        result.status  = status;
        result.unit_id = held_id_next;
        result.relays  = held_relays_next;
        result.volume  = held_volume_next;
        result.mute    = held_mute_next;
    end

    // Output register with one skid entry behind it.
    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;

        if (accept_last) begin
            if (!out_valid_reg || take) begin
                out_next       = result;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end else if (take) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg         <= 4'd0;
            crc_reg           <= ccfr_pkg::CRC_INIT;
            staged_id_reg     <= 8'h00;
            staged_relays_reg <= '0;
            staged_volume_reg <= 16'h0000;
            staged_mute_reg   <= 1'b0;
            held_id_reg       <= 8'h00;
            held_relays_reg   <= '0;
            held_volume_reg   <= 16'h0000;
            held_mute_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end else begin
            count_reg         <= count_next;
            crc_reg           <= crc_next;
            staged_id_reg     <= staged_id_next;
            staged_relays_reg <= staged_relays_next;
            staged_volume_reg <= staged_volume_next;
            staged_mute_reg   <= staged_mute_next;
            held_id_reg       <= held_id_next;
            held_relays_reg   <= held_relays_next;
            held_volume_reg   <= held_volume_next;
            held_mute_reg     <= held_mute_next;
            out_valid_reg     <= out_valid_next;
            skid_valid_reg    <= skid_valid_next;
        end
    end

    // Result payload registers need no reset.
    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // Result channel ports.
    assign m_valid        = out_valid_reg;
    assign m_frame_status = out_reg.status;
    assign m_unit_id      = out_reg.unit_id;
    assign m_relay_bits   = out_reg.relays;
    assign m_volume_level = out_reg.volume;
    assign m_mute_flag    = out_reg.mute;

endmodule
